// ----- rtl/bmh_pkg.sv -----
// Shared types and codes for the binary min-heap block.
// Used by binary_min_heap and its checker; depends on nothing else.
package bmh_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHK,
        S_DN_CMP
    } state_t;

endpackage

// ----- rtl/bmh_ram.sv -----
// Key store of the heap: one write port and two registered read ports.
// Depends on bmh_pkg for the key type.
module bmh_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  bmh_pkg::key_t   wdata,
    input  logic [AW-1:0]   ra_addr,
    input  logic [AW-1:0]   rb_addr,
    output bmh_pkg::key_t   ra_data,
    output bmh_pkg::key_t   rb_data
);

    bmh_pkg::key_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

// ----- rtl/binary_min_heap.sv -----
// Top level of the binary min-heap priority queue of signed 32-bit keys.
// Depends on bmh_pkg and instantiates the key store bmh_ram.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; cmd selects insert (key_in is stored) or extract-minimum. Every request
// gives exactly one result, shown on status, min_out and count_out for one
// cycle while done is high. The receiver cannot stall, so the result must be
// captured in that cycle.
//
// An insert into a full heap or an extract from an empty heap gives its
// result in the cycle after the request. Otherwise the key is sifted up
// (insert) or down (extract) by L levels, at most log2(CAPACITY). Each
// level needs one read of the key store, whose data arrives in the next
// cycle, and then a compare and a write back. The sifting key stays in a
// register and only the final slot receives it.
//
// A new request may be given in the cycle where done is high. Reset clears the
// count of keys and the controller; the key store itself is not cleared, since
// only slots below the count are ever read.
module binary_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic signed [31:0]             key_in,
    output logic                           done,
    output logic [bmh_pkg::STATUS_W-1:0]   status,
    output logic signed [31:0]             min_out,
    output logic [bmh_pkg::COUNT_W-1:0]    count_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // Child indexes reach 2*CAPACITY, so they need two bits beyond an address.
    localparam int IW = AW + 2;

    bmh_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    bmh_pkg::key_t                 k_reg, k_next;
    bmh_pkg::key_t                 min_reg, min_next;
    logic [bmh_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          done_reg, done_next;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    bmh_pkg::key_t                 mem_wdata;
    logic [AW-1:0]                 ra_addr;
    logic [AW-1:0]                 rb_addr;
    bmh_pkg::key_t                 ra_data;
    bmh_pkg::key_t                 rb_data;

    logic                          accept;
    logic                          heap_full;
    logic                          heap_empty;
    logic [AW-1:0]                 parent_addr;
    logic                          up_top;
    logic                          up_swap;
    logic [IW-1:0]                 l_idx;
    logic [IW-1:0]                 r_idx;
    logic                          dn_leaf;
    logic                          r_ok;
    logic                          take_l;
    logic                          take_r;
    bmh_pkg::key_t                 cand;
    logic                          dn_move;

    assign busy       = (state_reg != bmh_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign heap_full  = (count_reg >= CW'(CAPACITY));
    assign heap_empty = (count_reg == '0);

    // Sift-up: the parent of the hole is read, then compared with the key.
    assign parent_addr = (pos_reg - AW'(1)) >> 1;
    assign up_top      = (pos_reg == '0);
    assign up_swap     = (ra_data > k_reg);

    // Sift-down: both children are read together, one per read port. The
    // left child wins a tie, and a child replaces the key only when strictly smaller.
    assign l_idx   = {1'b0, pos_reg, 1'b1};
    assign r_idx   = l_idx + IW'(1);
    assign dn_leaf = (l_idx >= IW'(count_reg));
    assign r_ok    = (r_idx < IW'(count_reg));
    assign take_l  = (ra_data < k_reg);
    assign cand    = take_l ? ra_data : k_reg;
    assign take_r  = r_ok && (rb_data < cand);
    assign dn_move = take_l || take_r;

    bmh_ram #(
        .DEPTH(CAPACITY),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .ra_addr(ra_addr),
        .rb_addr(rb_addr),
        .ra_data(ra_data),
        .rb_data(rb_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == bmh_pkg::CMD_INSERT)
                    begin
                        if (!heap_full)
                        begin
                            state_next = bmh_pkg::S_UP_CHK;
                        end
                    end
                    else if (!heap_empty)
                    begin
                        state_next = bmh_pkg::S_DN_LOAD;
                    end
                end
            end
            bmh_pkg::S_UP_CHK:
            begin
                state_next = up_top ? bmh_pkg::S_IDLE : bmh_pkg::S_UP_CMP;
            end
            bmh_pkg::S_UP_CMP:
            begin
                state_next = up_swap ? bmh_pkg::S_UP_CHK : bmh_pkg::S_IDLE;
            end
            bmh_pkg::S_DN_LOAD:
            begin
                state_next = bmh_pkg::S_DN_CHK;
            end
            bmh_pkg::S_DN_CHK:
            begin
                state_next = dn_leaf ? bmh_pkg::S_IDLE : bmh_pkg::S_DN_CMP;
            end
            bmh_pkg::S_DN_CMP:
            begin
                state_next = dn_move ? bmh_pkg::S_DN_CHK : bmh_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bmh_pkg::S_IDLE;
            end
        endcase
    end

    // Memory control and datapath updates.
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        min_next    = min_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = k_reg;
        ra_addr     = '0;
        rb_addr     = AW'(count_reg - CW'(1));
        case (state_reg)
            bmh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    min_next    = '0;
                    status_next = bmh_pkg::STAT_OK;
                    if (cmd == bmh_pkg::CMD_INSERT)
                    begin
                        if (heap_full)
                        begin
                            status_next = bmh_pkg::STAT_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            pos_next   = AW'(count_reg);
                            k_next     = key_in;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (heap_empty)
                    begin
                        status_next = bmh_pkg::STAT_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // Root and last key are read now and arrive next cycle.
                        pos_next   = '0;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            bmh_pkg::S_UP_CHK:
            begin
                ra_addr = parent_addr;
                if (up_top)
                begin
                    mem_we    = 1'b1;
                    done_next = 1'b1;
                end
            end
            bmh_pkg::S_UP_CMP:
            begin
                ra_addr = parent_addr;
                mem_we  = 1'b1;
                if (up_swap)
                begin
                    mem_wdata = ra_data;
                    pos_next  = parent_addr;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            bmh_pkg::S_DN_LOAD:
            begin
                min_next = ra_data;
                k_next   = rb_data;
            end
            bmh_pkg::S_DN_CHK:
            begin
                ra_addr = AW'(l_idx);
                rb_addr = AW'(r_idx);
                if (dn_leaf)
                begin
                    mem_we    = 1'b1;
                    done_next = 1'b1;
                end
            end
            bmh_pkg::S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (dn_move)
                begin
                    mem_wdata = take_r ? rb_data : ra_data;
                    pos_next  = take_r ? AW'(r_idx) : AW'(l_idx);
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmh_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        min_reg    <= min_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign min_out   = min_reg;
    assign count_out = bmh_pkg::COUNT_W'(count_reg);

endmodule

// ----- rtl/binary_min_heap_chk.sv -----
// Port-level checker for binary_min_heap, attached to it by a bind statement.
// Depends on bmh_pkg for the status codes.
module binary_min_heap_chk #(
    parameter int CAPACITY = 1024
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [bmh_pkg::STATUS_W-1:0]  status,
    input logic signed [31:0]            min_out,
    input logic [bmh_pkg::COUNT_W-1:0]   count_out
);

    // Every accepted request is either answered or still in progress.
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted request neither in progress nor answered");

    // A dropped insert reports a full heap.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == bmh_pkg::STAT_FULL
            |-> count_out == bmh_pkg::COUNT_W'(CAPACITY) && min_out == '0)
        else $error("full status with wrong count or key");

    // An extract from an empty heap leaves it empty and returns zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == bmh_pkg::STAT_EMPTY |-> count_out == '0 && min_out == '0)
        else $error("empty status with nonzero count or key");

    // The block raises busy for a request only after taking it.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

endmodule

bind binary_min_heap binary_min_heap_chk #(.CAPACITY(CAPACITY)) u_chk (.*);

// ----- verif/bmh_checker.sv -----
`timescale 1ns / 1ps
// Checker for the binary min-heap: keeps its own heap of keys, predicts the
// result of every accepted request and compares each done strobe against it.
// Depends on bmh_pkg; instantiated beside the block by tb_binary_min_heap.
module bmh_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          cmd,
    input  bmh_pkg::key_t                 key_in,
    input  logic                          done,
    input  logic [bmh_pkg::STATUS_W-1:0]  status,
    input  bmh_pkg::key_t                 min_out,
    input  logic [bmh_pkg::COUNT_W-1:0]   count_out,
    output int                            fail_count,
    output int                            outstanding
);

    typedef struct packed {
        logic [bmh_pkg::STATUS_W-1:0] status;
        bmh_pkg::key_t                min_key;
        logic [bmh_pkg::COUNT_W-1:0]  count;
    } heap_result_t;

    heap_result_t  expected_results[$];
    bmh_pkg::key_t heap_keys[CAPACITY];
    int            heap_size;
    int            mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one request to the shadow heap and returns the result it causes.
    function automatic heap_result_t apply_request(input logic op, input bmh_pkg::key_t key);
        heap_result_t  res;
        int            pos;
        int            up;
        int            lc;
        int            rc;
        int            best;
        bmh_pkg::key_t tmp;
        res.status  = bmh_pkg::STAT_OK;
        res.min_key = '0;
        if (op == bmh_pkg::CMD_INSERT)
        begin
            if (heap_size >= CAPACITY)
            begin
                res.status = bmh_pkg::STAT_FULL;
            end
            else
            begin
                pos = heap_size;
                heap_keys[pos] = key;
                // Sift up while the parent is strictly greater.
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] > heap_keys[pos])
                    begin
                        tmp = heap_keys[up];
                        heap_keys[up] = heap_keys[pos];
                        heap_keys[pos] = tmp;
                        pos = up;
                    end
                    else
                    begin
                        break;
                    end
                end
                heap_size++;
            end
        end
        else
        begin
            if (heap_size == 0)
            begin
                res.status = bmh_pkg::STAT_EMPTY;
            end
            else
            begin
                res.min_key = heap_keys[0];
                heap_keys[0] = heap_keys[heap_size - 1];
                heap_size--;
                // Sift down toward the smaller child, left one on a tie.
                pos = 0;
                while (1)
                begin
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_size && heap_keys[lc] < heap_keys[best])
                        best = lc;
                    if (rc < heap_size && heap_keys[rc] < heap_keys[best])
                        best = rc;
                    if (best == pos)
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        res.count = heap_size[bmh_pkg::COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_result_t want;
        if (!rst_n)
        begin
            heap_size = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report("unrequested result (status)", status, -1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (min_out !== want.min_key)
                        report("min_out", min_out, want.min_key);
                    if (count_out !== want.count)
                        report("count_out", count_out, want.count);
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(cmd, key_in));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- verif/tb_binary_min_heap.sv -----
`timescale 1ns / 1ps
// Top of the binary min-heap testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on bmh_pkg, binary_min_heap and bmh_checker.
module tb_binary_min_heap;

    localparam int CAPACITY = 1024;
    // Longest quiet stretch in a correct run is an idle gap plus one full
    // sift; this limit is many times that.
    localparam int WATCHDOG_LIMIT = 4000;
    // Tail wait after the last result, well above the longest operation.
    localparam int DRAIN_CYCLES = 60;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           cmd;
    bmh_pkg::key_t                  key_in;
    logic                           done;
    logic [bmh_pkg::STATUS_W-1:0]   status;
    bmh_pkg::key_t                  min_out;
    logic [bmh_pkg::COUNT_W-1:0]    count_out;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    // Percentage of request slots in which the sender holds back.
    int idle_pct;
    // The stimulus keeps its own rough idea of the fill level, only to steer
    // the mix of inserts and extracts; all checking lives in the checker.
    int fill_level;

    binary_min_heap #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .key_in    (key_in),
        .done      (done),
        .status    (status),
        .min_out   (min_out),
        .count_out (count_out)
    );

    bmh_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .key_in      (key_in),
        .done        (done),
        .status      (status),
        .min_out     (min_out),
        .count_out   (count_out),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: any cycle with neither an accepted request nor a result
    // counts toward the limit; a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[binary_min_heap] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Keys are drawn so that ties, the signed extremes and fully random
    // 32-bit patterns all show up; small keys make equal-key sifts common.
    function automatic bmh_pkg::key_t random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return bmh_pkg::key_t'($signed($urandom_range(16)) - 8);
        else if (pick < 34)
            return 32'sh7fff_ffff;
        else if (pick < 38)
            return 32'sh8000_0000;
        else if (pick < 40)
            return bmh_pkg::key_t'(-1);
        else
            return bmh_pkg::key_t'($urandom);
    endfunction

    // Presents one request and returns once it has been taken. When the
    // sender idles, start drops for a random stretch, so the gap lands on
    // any phase of the sift that is running. start is never lowered and
    // raised at the same edge.
    task automatic issue(input logic op, input bmh_pkg::key_t key);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= op;
        key_in <= key;
        // The request is taken at the first edge that sees busy low.
        do @(posedge clk); while (busy);
        if (op == bmh_pkg::CMD_INSERT)
        begin
            if (fill_level < CAPACITY)
                fill_level++;
        end
        else if (fill_level > 0)
        begin
            fill_level--;
        end
    endtask

    // Random mix; insert_pct steers whether the heap grows or shrinks.
    task automatic random_request(input int insert_pct);
        if ($urandom_range(99) < insert_pct)
            issue(bmh_pkg::CMD_INSERT, random_key());
        else
            issue(bmh_pkg::CMD_EXTRACT, bmh_pkg::key_t'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = bmh_pkg::CMD_INSERT;
        key_in     = '0;
        fill_level = 0;
        idle_pct   = 18;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extract from an empty heap, the signed extremes, equal
        // keys and a duplicated minimum, then drain past empty again.
        issue(bmh_pkg::CMD_EXTRACT, 32'sh1234_5678);
        issue(bmh_pkg::CMD_INSERT, 32'sh7fff_ffff);
        issue(bmh_pkg::CMD_INSERT, 32'sh8000_0000);
        issue(bmh_pkg::CMD_INSERT, 32'sh0000_0000);
        issue(bmh_pkg::CMD_INSERT, bmh_pkg::key_t'(-1));
        issue(bmh_pkg::CMD_INSERT, 32'sh0000_0005);
        issue(bmh_pkg::CMD_INSERT, 32'sh0000_0005);
        issue(bmh_pkg::CMD_INSERT, 32'sh0000_0005);
        issue(bmh_pkg::CMD_INSERT, 32'sh8000_0000);
        issue(bmh_pkg::CMD_INSERT, 32'sh5555_aaaa);
        repeat (9) issue(bmh_pkg::CMD_EXTRACT, bmh_pkg::key_t'(-1));
        repeat (2) issue(bmh_pkg::CMD_EXTRACT, '0);

        // Mixed traffic with a slowly growing heap, sender idling lightly.
        repeat (200) random_request(60);

        // Heavier idling while the heap is filled to capacity. Inserts into
        // the full heap are dropped; an extract in between reopens one slot.
        idle_pct = 57;
        while (fill_level < CAPACITY)
            random_request(95);
        repeat (4) issue(bmh_pkg::CMD_INSERT, random_key());
        issue(bmh_pkg::CMD_EXTRACT, '0);
        repeat (4) issue(bmh_pkg::CMD_INSERT, random_key());

        // Back-to-back requests, extracts and inserts interleaved on a
        // slowly shrinking heap.
        idle_pct = 0;
        repeat (700) random_request(40);

        start <= 1'b0;
        // Let the checker see the last request, then wait for every
        // outstanding result; the watchdog covers a result that never comes.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[binary_min_heap] OK");
        else
            $display("[binary_min_heap] ERROR");
        $finish;
    end

endmodule

// ----- binary_min_heap.f -----
rtl/bmh_pkg.sv
rtl/bmh_ram.sv
rtl/binary_min_heap.sv
rtl/binary_min_heap_chk.sv
verif/bmh_checker.sv
verif/tb_binary_min_heap.sv
